FILE: hdl/orlm_pkg.sv
// package for the ordered row lock manager
// entry type, event codes, mode codes and priority compare; no dependencies
`default_nettype none
package orlm_pkg;
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  // event log: most words one request can cause
  localparam int unsigned EvDepth = MaxEntries + 1;
  localparam int unsigned EvIdxW = $clog2(EvDepth);
  localparam int unsigned EvCntW = $clog2(EvDepth + 1);

  localparam logic [2:0] EvGranted  = 3'd0;
  localparam logic [2:0] EvWaits    = 3'd1;
  localparam logic [2:0] EvDeprived = 3'd2;
  localparam logic [2:0] EvWgranted = 3'd3;
  localparam logic [2:0] EvReleased = 3'd4;
  localparam logic [2:0] EvUnknown  = 3'd5;
  localparam logic [2:0] EvFull     = 3'd6;

  localparam logic [1:0] ModeNone = 2'd0;
  localparam logic [1:0] ModeShr  = 2'd1;
  localparam logic [1:0] ModeExc  = 2'd2;

  typedef struct packed {
    logic [23:0] batch;
    logic [14:0] okey;
    logic [23:0] tid;
    logic        mode;
  } ent_t;

  // a older than b
  function automatic logic older(ent_t a, ent_t b);
    logic r;
    if (a.batch != b.batch) r = a.batch < b.batch;
    else if (a.okey != b.okey) r = a.okey < b.okey;
    else r = a.tid < b.tid;
    return r;
  endfunction

  function automatic logic conflicts(logic [1:0] cur, logic m);
    return (cur != ModeNone) && ((cur == ModeExc) || m);
  endfunction
endpackage
`default_nettype wire

FILE: hdl/ordered_row_lock_manager_top.sv
// ordered row lock manager top: sequencer, entry stores, event log, output register; uses orlm_pkg
// after accept the request is decided, walks read or move entries as needed, and each event is logged;
// a release reshifts the waiters once per grant; logged words are then handed out in order
// one request at a time: a new request is taken only after the last word of the previous one is loaded
// into the output register, and output stalls hold the sequencer while words are handed out
// reset: state, counts and held mode clear; entry stores are left as they are
`default_nettype none
module ordered_row_lock_manager_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [0] req_type [1] lock_mode [25:2] batch [40:26] order_key [64:41] txn_id
  input  wire logic [71:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [2:0] event_res [26:3] ev_batch [41:27] ev_order_key [65:42] ev_txn_id
  // [67:66] held_mode
  output logic [71:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);
  localparam int unsigned N = orlm_pkg::MaxEntries;
  localparam int unsigned IW = orlm_pkg::IdxW;
  localparam int unsigned CW = orlm_pkg::CntW;
  localparam int unsigned ED = orlm_pkg::EvDepth;
  localparam int unsigned EIW = orlm_pkg::EvIdxW;
  localparam int unsigned ECW = orlm_pkg::EvCntW;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_DEC  = 12'b000000000010,  // decide on request
    S_RSCH = 12'b000000000100,  // release: search owners
    S_RSHF = 12'b000000001000,  // release: close gap in owners
    S_GCHK = 12'b000000010000,  // grant check on waiter head
    S_GSHF = 12'b000000100000,  // shift waiters down by one
    S_WPOS = 12'b000001000000,  // waiter insert position search
    S_WSHF = 12'b000010000000,  // waiters shift up to open gap
    S_OPOS = 12'b000100000000,  // owner position search
    S_MOVE = 12'b001000000000,  // owner insert shift or preemption move
    S_EMIT = 12'b010000000000,  // log one event
    S_DRN  = 12'b100000000000   // hand out logged words
  } state_e;

  // one logged event: code and the entry it concerns
  typedef struct packed {
    logic [2:0]     ev;
    orlm_pkg::ent_t ent;
  } evrec_t;

  state_e state_q, state_d, ret_q, ret_d;

  // stores, one read port each, registered read data
  orlm_pkg::ent_t own_mem [N];
  orlm_pkg::ent_t wai_mem [N];
  orlm_pkg::ent_t own_rd_q, wai_rd_q;
  logic [IW-1:0]  own_ra, wai_ra, own_wa, wai_wa;
  logic           own_we, wai_we;
  orlm_pkg::ent_t own_wd, wai_wd;

  // event log of the current request, drained once the held mode is final
  evrec_t         ev_mem [ED];
  evrec_t         ev_rd_q;
  logic [EIW-1:0] ev_ra;
  logic           ev_we;

  always_ff @(posedge clk_i) begin
    if (own_we) own_mem[own_wa] <= own_wd;
    if (wai_we) wai_mem[wai_wa] <= wai_wd;
    if (ev_we) ev_mem[ecnt_q[EIW-1:0]] <= '{ev: oev_q, ent: oent_q};
    own_rd_q <= own_mem[own_ra];
    wai_rd_q <= wai_mem[wai_ra];
    ev_rd_q  <= ev_mem[ev_ra];
  end

  logic [CW-1:0] ocnt_q, ocnt_d, wcnt_q, wcnt_d;
  logic [1:0]    mode_q, mode_d;
  orlm_pkg::ent_t rq_q, rq_d;
  logic          rel_q, rel_d;
  logic [CW-1:0] i_q, i_d, p_q, p_d;  // walk pointer and found position
  logic          rd_ok_q, rd_ok_d;    // read data matches pointer
  logic [2:0]    phase_q, phase_d;    // sub-phase of a move

  // staged event fields, logged in S_EMIT
  logic [2:0]    oev_q, oev_d;
  orlm_pkg::ent_t oent_q, oent_d;
  // event log fill count and drain pointer
  logic [ECW-1:0] ecnt_q, ecnt_d, dp_q, dp_d;
  // output register; held mode is captured with the word
  logic          ov_q, ov_d;
  logic [67:0]   odat_q, odat_d;
  logic          olast_q, olast_d;
  // preemption shift amount: deprived owners, plus one for the requester when it waits (p > 0)
  logic [CW-1:0] k_q, k_d;

  orlm_pkg::ent_t rq_in;
  assign rq_in = '{batch: s_axis_tdata_i[25:2], okey: s_axis_tdata_i[40:26],
                   tid: s_axis_tdata_i[64:41], mode: s_axis_tdata_i[1]};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {4'd0, odat_q};

  always_comb begin
    state_d = state_q; ret_d = ret_q;
    ocnt_d = ocnt_q; wcnt_d = wcnt_q; mode_d = mode_q;
    rq_d = rq_q; rel_d = rel_q; i_d = i_q; p_d = p_q; rd_ok_d = 1'b0;
    phase_d = phase_q; k_d = k_q;
    oev_d = oev_q; oent_d = oent_q;
    ecnt_d = ecnt_q; dp_d = dp_q;
    ov_d = ov_q; odat_d = odat_q; olast_d = olast_q;
    own_ra = i_q[IW-1:0]; wai_ra = i_q[IW-1:0];
    own_we = 1'b0; wai_we = 1'b0;
    own_wa = i_q[IW-1:0]; wai_wa = i_q[IW-1:0];
    own_wd = own_rd_q; wai_wd = wai_rd_q;
    ev_we = 1'b0; ev_ra = dp_q[EIW-1:0];
    if (ov_q && m_axis_tready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          rq_d = rq_in; rel_d = s_axis_tdata_i[0];
          state_d = S_DEC; i_d = '0;
          ecnt_d = '0; dp_d = '0;
          own_ra = IW'(ocnt_q - CW'(1));
        end
      end
      S_DEC: begin
        // own_rd_q holds youngest owner when ocnt_q > 0
        if (rel_q) begin
          i_d = '0; state_d = S_RSCH;
        end else if ({1'b0, ocnt_q} + {1'b0, wcnt_q} >= (CW+1)'(N)) begin
          oev_d = orlm_pkg::EvFull; oent_d = rq_q;
          state_d = S_EMIT; ret_d = S_IDLE;
        end else if (ocnt_q == '0) begin
          own_we = 1'b1; own_wa = '0; own_wd = rq_q;
          ocnt_d = CW'(1); mode_d = {1'b0, rq_q.mode} + 2'd1;
          oev_d = orlm_pkg::EvGranted; oent_d = rq_q;
          state_d = S_EMIT; ret_d = S_IDLE;
        end else if (orlm_pkg::older(own_rd_q, rq_q)) begin
          // search waiters from the tail
          p_d = wcnt_q; i_d = wcnt_q; state_d = S_WPOS;
          wai_ra = IW'(wcnt_q - CW'(1));
        end else begin
          i_d = '0; state_d = S_OPOS;
        end
      end
      S_RSCH: begin
        // step: issue read i, check next cycle
        if (!rd_ok_q) begin
          if (i_q >= ocnt_q) begin
            oev_d = orlm_pkg::EvUnknown; oent_d = rq_q;
            state_d = S_EMIT; ret_d = S_IDLE;
          end else begin
            own_ra = i_q[IW-1:0]; rd_ok_d = 1'b1;
          end
        end else if (own_rd_q.tid == rq_q.tid) begin
          oev_d = orlm_pkg::EvReleased; oent_d = own_rd_q;
          state_d = S_EMIT; ret_d = S_RSHF;
          ocnt_d = ocnt_q - CW'(1);
          if (ocnt_q == CW'(1)) mode_d = orlm_pkg::ModeNone;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_RSHF: begin
        // move owner i+1 down to i until end
        if (!rd_ok_q) begin
          if (i_q >= ocnt_q) begin
            state_d = S_GCHK; wai_ra = '0;
          end else begin
            own_ra = IW'(i_q + CW'(1)); rd_ok_d = 1'b1;
          end
        end else begin
          own_we = 1'b1; own_wa = i_q[IW-1:0]; own_wd = own_rd_q;
          i_d = i_q + CW'(1);
        end
      end
      S_GCHK: begin
        // wai_rd_q is waiter head
        if (wcnt_q != '0 && ocnt_q < CW'(N) &&
            !orlm_pkg::conflicts(mode_q, wai_rd_q.mode)) begin
          own_we = 1'b1; own_wa = ocnt_q[IW-1:0]; own_wd = wai_rd_q;
          ocnt_d = ocnt_q + CW'(1);
          mode_d = {1'b0, wai_rd_q.mode} + 2'd1;
          wcnt_d = wcnt_q - CW'(1);
          oev_d = orlm_pkg::EvWgranted; oent_d = wai_rd_q;
          i_d = '0; state_d = S_EMIT; ret_d = S_GSHF;
        end else begin
          // grant chain over, held mode is final
          state_d = S_DRN;
        end
      end
      S_GSHF: begin
        if (!rd_ok_q) begin
          if (i_q >= wcnt_q) begin
            state_d = S_GCHK; wai_ra = '0;
          end else begin
            wai_ra = IW'(i_q + CW'(1)); rd_ok_d = 1'b1;
          end
        end else begin
          wai_we = 1'b1; wai_wa = i_q[IW-1:0]; wai_wd = wai_rd_q;
          i_d = i_q + CW'(1);
        end
      end
      S_WPOS: begin
        // wai_rd_q is entry p-1
        if (p_q != '0 && orlm_pkg::older(rq_q, wai_rd_q)) begin
          p_d = p_q - CW'(1);
          wai_ra = IW'(p_q - CW'(2));
          rd_ok_d = 1'b0;
        end else if (!orlm_pkg::conflicts(mode_q, rq_q.mode) &&
                     (wcnt_q == '0 || p_q == '0)) begin
          own_we = 1'b1; own_wa = ocnt_q[IW-1:0]; own_wd = rq_q;
          ocnt_d = ocnt_q + CW'(1); mode_d = {1'b0, rq_q.mode} + 2'd1;
          oev_d = orlm_pkg::EvGranted; oent_d = rq_q;
          state_d = S_EMIT; ret_d = S_IDLE;
        end else begin
          i_d = wcnt_q; state_d = S_WSHF;
        end
      end
      S_WSHF: begin
        // move waiter i-1 up to i for i down to p+1, then store rq at p
        if (!rd_ok_q) begin
          if (i_q == p_q) begin
            wai_we = 1'b1; wai_wa = p_q[IW-1:0]; wai_wd = rq_q;
            wcnt_d = wcnt_q + CW'(1);
            oev_d = orlm_pkg::EvWaits; oent_d = rq_q;
            state_d = S_EMIT; ret_d = S_IDLE;
          end else begin
            wai_ra = IW'(i_q - CW'(1)); rd_ok_d = 1'b1;
          end
        end else begin
          wai_we = 1'b1; wai_wa = i_q[IW-1:0]; wai_wd = wai_rd_q;
          i_d = i_q - CW'(1);
        end
      end
      S_OPOS: begin
        if (!rd_ok_q) begin
          if (i_q >= ocnt_q) begin
            p_d = i_q; state_d = S_MOVE; phase_d = 3'd0;
            i_d = ocnt_q;
          end else begin
            own_ra = i_q[IW-1:0]; rd_ok_d = 1'b1;
          end
        end else if (orlm_pkg::older(own_rd_q, rq_q)) begin
          i_d = i_q + CW'(1);
        end else begin
          p_d = i_q; state_d = S_MOVE; phase_d = 3'd0; i_d = ocnt_q;
        end
      end
      S_MOVE: begin
        if (!orlm_pkg::conflicts(mode_q, rq_q.mode)) begin
          // shift owners i-1 -> i down to p, then store rq at p
          if (!rd_ok_q) begin
            if (i_q == p_q) begin
              own_we = 1'b1; own_wa = p_q[IW-1:0]; own_wd = rq_q;
              ocnt_d = ocnt_q + CW'(1); mode_d = {1'b0, rq_q.mode} + 2'd1;
              oev_d = orlm_pkg::EvGranted; oent_d = rq_q;
              state_d = S_EMIT; ret_d = S_IDLE;
            end else begin
              own_ra = IW'(i_q - CW'(1)); rd_ok_d = 1'b1;
            end
          end else begin
            own_we = 1'b1; own_wa = i_q[IW-1:0]; own_wd = own_rd_q;
            i_d = i_q - CW'(1);
          end
        end else begin
          // preemption; k = shift amount = d (+1 if p>0)
          unique case (phase_q)
            3'd0: begin
              k_d = (ocnt_q - p_q) + ((p_q != '0) ? CW'(1) : CW'(0));
              i_d = wcnt_q; phase_d = 3'd1;
            end
            3'd1: begin
              // waiters i-1 -> i-1+k, i down to 1
              if (!rd_ok_q) begin
                if (i_q == '0) begin
                  phase_d = 3'd2; i_d = p_q;
                end else begin
                  wai_ra = IW'(i_q - CW'(1)); rd_ok_d = 1'b1;
                end
              end else begin
                wai_we = 1'b1; wai_wa = IW'(i_q - CW'(1) + k_q);
                wai_wd = wai_rd_q; i_d = i_q - CW'(1);
              end
            end
            3'd2: begin
              // owner i -> waiter (i-p)+(k-d), report deprived
              if (!rd_ok_q) begin
                if (i_q >= ocnt_q) begin
                  phase_d = 3'd3;
                end else begin
                  own_ra = i_q[IW-1:0]; rd_ok_d = 1'b1;
                end
              end else begin
                wai_we = 1'b1;
                wai_wa = IW'(i_q - p_q + ((p_q != '0) ? CW'(1) : CW'(0)));
                wai_wd = own_rd_q;
                oev_d = orlm_pkg::EvDeprived; oent_d = own_rd_q;
                i_d = i_q + CW'(1); state_d = S_EMIT; ret_d = S_MOVE;
              end
            end
            default: begin
              wcnt_d = wcnt_q + k_q;
              if (p_q != '0) begin
                wai_we = 1'b1; wai_wa = '0; wai_wd = rq_q;
                ocnt_d = p_q;
                oev_d = orlm_pkg::EvWaits;
              end else begin
                own_we = 1'b1; own_wa = '0; own_wd = rq_q;
                ocnt_d = CW'(1); mode_d = {1'b0, rq_q.mode} + 2'd1;
                oev_d = orlm_pkg::EvGranted;
              end
              oent_d = rq_q;
              state_d = S_EMIT; ret_d = S_IDLE;
            end
          endcase
        end
      end
      S_EMIT: begin
        // staged event goes into the log; the walk resumes next cycle, or the drain starts if the request is done
        ev_we = 1'b1;
        ecnt_d = ecnt_q + ECW'(1);
        if (ret_q == S_IDLE) begin
          state_d = S_DRN;
        end else begin
          state_d = ret_q;
          if (ret_q == S_GSHF) i_d = '0;
        end
      end
      S_DRN: begin
        // read log entry, then load it into the output register once free;
        // held mode no longer changes here, so every word carries the final one
        if (!rd_ok_q) begin
          if (dp_q == ecnt_q) begin
            state_d = S_IDLE;
          end else begin
            rd_ok_d = 1'b1;
          end
        end else if (!ov_q || m_axis_tready_i) begin
          ov_d = 1'b1;
          odat_d = {mode_q, ev_rd_q.ent.tid, ev_rd_q.ent.okey, ev_rd_q.ent.batch,
                    ev_rd_q.ev};
          olast_d = (dp_q + ECW'(1) == ecnt_q);
          dp_d = dp_q + ECW'(1);
        end else begin
          // output busy: keep reading the same entry
          rd_ok_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE;
      ocnt_q <= '0; wcnt_q <= '0; mode_q <= orlm_pkg::ModeNone;
      ov_q <= 1'b0; rd_ok_q <= 1'b0; phase_q <= '0;
      ecnt_q <= '0; dp_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d;
      ocnt_q <= ocnt_d; wcnt_q <= wcnt_d; mode_q <= mode_d;
      ov_q <= ov_d; rd_ok_q <= rd_ok_d; phase_q <= phase_d;
      ecnt_q <= ecnt_d; dp_q <= dp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; rel_q <= rel_d; i_q <= i_d; p_q <= p_d; k_q <= k_d;
    oev_q <= oev_d; oent_q <= oent_d;
    odat_q <= odat_d; olast_q <= olast_d;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ocnt_q} + {1'b0, wcnt_q}) <= (CW+1)'(N))
    else $error("entry counts exceed store size");
  a_mode_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((ocnt_q == '0) == (mode_q == orlm_pkg::ModeNone)))
    else $error("held mode disagrees with owner count");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready while a request is in work");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("output word changed while stalled");
`endif
endmodule
`default_nettype wire
